@@ hdl/sbpa_pkg.sv @@
package sbpa_pkg;

   // Default band count handed to the top level.
   localparam int NUM_BANDS_DEF = 8;

   // Number of FFT bins in one frame; a bin index at or above it is ignored.
   localparam int BIN_COUNT = 64;

   // Field widths.
   localparam int BIN_W      = 6;
   localparam int MAG_W      = 16;
   localparam int BAND_NUM_W = 3;
   localparam int BPB_W      = 4;
   localparam int MARGIN_W   = 4;
   localparam int RATE_W     = 12;

   // Configuration port widths.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Shared divider: the widest dividend is a 16-bit level times a 4-bit numerator.
   localparam int DIV_W = MAG_W + MARGIN_W;
   localparam int DEN_W = RATE_W;

   // Scale after reset and the held-peak decay of 15/16.
   localparam logic [MAG_W-1:0] SCALE_RESET = 16'd16;
   localparam int PEAK_DECAY_SHIFT = 4;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_BIN     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BINS_PER_BAND = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_NOISE_FLOOR   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MARGIN_NUM    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MARGIN_DEN    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ATTACK_DIV    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELEASE_DIV   = 3'd6;

   // Which quotient the shared divider is working on.
   typedef enum logic [1:0] {
      DIV_TARGET,
      DIV_FLOOR,
      DIV_GAP
   } div_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        capture;
      logic        map_en;
      logic        acc_en;
      logic        walk_en;
      logic        div_start;
      div_sel_type div_sel;
      logic        scale_en;
      logic        emit_take;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_done;
      logic frame_end;
   } dp_status_type;

endpackage

@@ hdl/sbpa_divider.sv @@
module sbpa_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [sbpa_pkg::DIV_W-1:0]   dividend,
   input  logic [sbpa_pkg::DEN_W-1:0]   divisor,
   output logic                         done,
   output logic [sbpa_pkg::DIV_W-1:0]   quotient
);
   import sbpa_pkg::*;

   localparam int CNT_W = $clog2(DIV_W + 1);

   // Restoring division, one quotient bit per cycle. The dividend shifts out of
   // the top of quo_ff while quotient bits shift in at the bottom.
   logic [DIV_W-1:0] quo_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] count_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [DEN_W:0]   rem_sh;
   logic             q_bit;
   logic [DEN_W:0]   rem_diff;

   always_comb begin
      rem_sh   = {rem_ff, quo_ff[DIV_W-1]};
      q_bit    = (rem_sh >= {1'b0, den_ff});
      rem_diff = rem_sh - {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= CNT_W'(DIV_W);
         end else if (busy_ff) begin
            count_ff <= count_ff - 1'b1;
            if (count_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DIV_W-2:0], q_bit};
         rem_ff <= q_bit ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ hdl/sbpa_datapath.sv @@
module sbpa_datapath #(
   parameter int NUM_BANDS = sbpa_pkg::NUM_BANDS_DEF,
   localparam int BAND_W = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   input  logic [sbpa_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sbpa_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [sbpa_pkg::BIN_W-1:0]        req_bin_index,
   input  logic [sbpa_pkg::MAG_W-1:0]        req_magnitude,
   input  logic                              req_frame_end,
   input  sbpa_pkg::dp_cmd_type              cmd,
   input  logic [BAND_W-1:0]                 idx,
   output sbpa_pkg::dp_status_type           sts,
   output logic [sbpa_pkg::MAG_W-1:0]        rsp_band_level,
   output logic [sbpa_pkg::MAG_W-1:0]        rsp_band_peak,
   output logic [sbpa_pkg::MAG_W-1:0]        rsp_display_scale
);
   import sbpa_pkg::*;

   localparam int PROD_W = $clog2(NUM_BANDS + 1) + BPB_W;

   // Configuration registers.
   logic [BIN_W-1:0]    first_bin_ff;
   logic [BPB_W-1:0]    bpb_ff;
   logic [MAG_W-1:0]    floor_ff;
   logic [MARGIN_W-1:0] mnum_ff;
   logic [MARGIN_W-1:0] mden_ff;
   logic [RATE_W-1:0]   attack_ff;
   logic [RATE_W-1:0]   release_ff;

   // Captured input transaction and its band.
   logic [BIN_W-1:0]    bin_ff;
   logic [MAG_W-1:0]    mag_ff;
   logic                fend_ff;
   logic [BAND_W-1:0]   band_ff;
   logic                hit_ff;

   // Band state.
   logic [MAG_W-1:0]    fbm_ff [NUM_BANDS];
   logic [MAG_W-1:0]    peak_ff [NUM_BANDS];

   // Scale computation.
   logic [MAG_W-1:0]    fmax_ff;
   logic [MAG_W-1:0]    target_ff;
   logic [MAG_W-1:0]    floor_scale_ff;
   logic [MAG_W-1:0]    gap_q_ff;
   logic [MAG_W-1:0]    scale_ff;

   logic [BIN_W-1:0]    offset_c;
   logic                in_range_c;
   logic [NUM_BANDS-1:0] thr_c;
   logic [BAND_W-1:0]   band_c;
   logic                hit_c;

   logic [MAG_W-1:0]    cur_c;
   logic [MAG_W-1:0]    level_c;
   logic [MAG_W-1:0]    peak_cur_c;
   logic [MAG_W+PEAK_DECAY_SHIFT-1:0] dec_c;
   logic [MAG_W-1:0]    peak_in;

   logic                up_c;
   logic [MAG_W-1:0]    gap_c;
   logic [MARGIN_W-1:0] mden_nz_c;
   logic [RATE_W-1:0]   attack_nz_c;
   logic [RATE_W-1:0]   release_nz_c;
   logic [DIV_W-1:0]    div_dividend;
   logic [DEN_W-1:0]    div_divisor;
   logic                div_done;
   logic [DIV_W-1:0]    div_quotient;
   logic [MAG_W-1:0]    quo_sat_c;
   logic [MAG_W-1:0]    scale_new_c;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         first_bin_ff <= 6'd1;
         bpb_ff       <= 4'd2;
         floor_ff     <= 16'd10;
         mnum_ff      <= 4'd8;
         mden_ff      <= 4'd5;
         attack_ff    <= 12'd12;
         release_ff   <= 12'd1000;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FIRST_BIN:     first_bin_ff <= csr_wdata[BIN_W-1:0];
            CSR_BINS_PER_BAND: bpb_ff       <= csr_wdata[BPB_W-1:0];
            CSR_NOISE_FLOOR:   floor_ff     <= csr_wdata[MAG_W-1:0];
            CSR_MARGIN_NUM:    mnum_ff      <= csr_wdata[MARGIN_W-1:0];
            CSR_MARGIN_DEN:    mden_ff      <= csr_wdata[MARGIN_W-1:0];
            CSR_ATTACK_DIV:    attack_ff    <= csr_wdata[RATE_W-1:0];
            CSR_RELEASE_DIV:   release_ff   <= csr_wdata[RATE_W-1:0];
            default: ;
         endcase
      end
   end

   // Band mapping: the band is the count of band boundaries k*bins_per_band
   // at or below the bin's offset into the span.
   always_comb begin
      offset_c   = bin_ff - first_bin_ff;
      in_range_c = (bpb_ff != '0) && (bin_ff >= first_bin_ff) &&
                   (32'(bin_ff) < 32'(BIN_COUNT));
      for (int k = 0; k < NUM_BANDS; k++) begin
         thr_c[k] = (PROD_W'(offset_c) >= PROD_W'(k + 1) * PROD_W'(bpb_ff));
      end
      band_c = '0;
      for (int k = 0; k < NUM_BANDS - 1; k++) begin
         if (thr_c[k]) begin
            band_c = BAND_W'(k + 1);
         end
      end
      hit_c = in_range_c && !thr_c[NUM_BANDS-1];
   end

   // Band walk: gate against the floor and update the held peak.
   always_comb begin
      cur_c      = fbm_ff[idx];
      level_c    = (cur_c < floor_ff) ? '0 : cur_c;
      peak_cur_c = peak_ff[idx];
      dec_c      = {peak_cur_c, {PEAK_DECAY_SHIFT{1'b0}}} -
                   {{PEAK_DECAY_SHIFT{1'b0}}, peak_cur_c};
      peak_in    = (level_c >= peak_cur_c) ? level_c : dec_c[MAG_W+PEAK_DECAY_SHIFT-1:PEAK_DECAY_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         bin_ff  <= req_bin_index;
         mag_ff  <= req_magnitude;
         fend_ff <= req_frame_end;
      end
      if (cmd.map_en) begin
         band_ff <= band_c;
         hit_ff  <= hit_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < NUM_BANDS; b++) begin
            fbm_ff[b]  <= '0;
            peak_ff[b] <= '0;
         end
      end else begin
         if (cmd.acc_en && hit_ff && (mag_ff > fbm_ff[band_ff])) begin
            fbm_ff[band_ff] <= mag_ff;
         end
         // The walk leaves the gated level in place until it is delivered.
         if (cmd.walk_en) begin
            fbm_ff[idx]  <= level_c;
            peak_ff[idx] <= peak_in;
         end
         if (cmd.emit_take) begin
            fbm_ff[idx] <= '0;
         end
      end
   end

   // Divider operands.
   always_comb begin
      up_c         = (target_ff > scale_ff);
      gap_c        = up_c ? (target_ff - scale_ff) : (scale_ff - target_ff);
      mden_nz_c    = (mden_ff == '0) ? MARGIN_W'(1) : mden_ff;
      attack_nz_c  = (attack_ff == '0) ? RATE_W'(1) : attack_ff;
      release_nz_c = (release_ff == '0) ? RATE_W'(1) : release_ff;
      unique case (cmd.div_sel)
         DIV_TARGET: begin
            div_dividend = DIV_W'(fmax_ff) * DIV_W'(mnum_ff);
            div_divisor  = DEN_W'(mden_nz_c);
         end
         DIV_FLOOR: begin
            div_dividend = DIV_W'(floor_ff) * DIV_W'(mnum_ff);
            div_divisor  = DEN_W'(mden_nz_c);
         end
         DIV_GAP: begin
            div_dividend = DIV_W'(gap_c);
            div_divisor  = up_c ? attack_nz_c : release_nz_c;
         end
         default: begin
            div_dividend = '0;
            div_divisor  = DEN_W'(1);
         end
      endcase
      quo_sat_c   = (div_quotient[DIV_W-1:MAG_W] != '0) ? '1 : div_quotient[MAG_W-1:0];
      scale_new_c = up_c ? (scale_ff + gap_q_ff) : (scale_ff - gap_q_ff);
   end

   sbpa_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (cmd.scale_en) begin
         scale_ff <= (scale_new_c < floor_scale_ff) ? floor_scale_ff : scale_new_c;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.acc_en) begin
         fmax_ff <= floor_ff;
      end else if (cmd.walk_en && (level_c > fmax_ff)) begin
         fmax_ff <= level_c;
      end
      if (div_done) begin
         unique case (cmd.div_sel)
            DIV_TARGET: target_ff      <= quo_sat_c;
            DIV_FLOOR:  floor_scale_ff <= quo_sat_c;
            DIV_GAP:    gap_q_ff       <= div_quotient[MAG_W-1:0];
            default: ;
         endcase
      end
   end

   assign sts.div_done  = div_done;
   assign sts.frame_end = fend_ff;

   assign rsp_band_level    = fbm_ff[idx];
   assign rsp_band_peak     = peak_ff[idx];
   assign rsp_display_scale = scale_ff;

endmodule

@@ hdl/sbpa_ctrl.sv @@
module sbpa_ctrl #(
   parameter int NUM_BANDS = sbpa_pkg::NUM_BANDS_DEF,
   localparam int BAND_W = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      rsp_stall,
   input  sbpa_pkg::dp_status_type   sts,
   output sbpa_pkg::dp_cmd_type      cmd,
   output logic [BAND_W-1:0]         idx,
   output logic                      req_stall,
   output logic                      rsp_valid,
   output logic                      rsp_last_band
);
   import sbpa_pkg::*;

   localparam logic [BAND_W-1:0] LAST_BAND = BAND_W'(NUM_BANDS - 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAP,
      ST_ACC,
      ST_WALK,
      ST_TGT_GO,
      ST_TGT_WAIT,
      ST_FLR_GO,
      ST_FLR_WAIT,
      ST_GAP_GO,
      ST_GAP_WAIT,
      ST_SCALE,
      ST_EMIT
   } state_type;

   state_type         state_ff;
   logic [BAND_W-1:0] idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE:     if (req_valid) state_ff <= ST_MAP;
            ST_MAP:      state_ff <= ST_ACC;
            ST_ACC: begin
               idx_ff   <= '0;
               state_ff <= sts.frame_end ? ST_WALK : ST_IDLE;
            end
            ST_WALK: begin
               if (idx_ff == LAST_BAND) begin
                  idx_ff   <= '0;
                  state_ff <= ST_TGT_GO;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_TGT_GO:   state_ff <= ST_TGT_WAIT;
            ST_TGT_WAIT: if (sts.div_done) state_ff <= ST_FLR_GO;
            ST_FLR_GO:   state_ff <= ST_FLR_WAIT;
            ST_FLR_WAIT: if (sts.div_done) state_ff <= ST_GAP_GO;
            ST_GAP_GO:   state_ff <= ST_GAP_WAIT;
            ST_GAP_WAIT: if (sts.div_done) state_ff <= ST_SCALE;
            ST_SCALE:    state_ff <= ST_EMIT;
            ST_EMIT: begin
               if (!rsp_stall) begin
                  if (idx_ff == LAST_BAND) begin
                     idx_ff   <= '0;
                     state_ff <= ST_IDLE;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end
            end
            default:     state_ff <= ST_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd           = '0;
      cmd.capture   = (state_ff == ST_IDLE) && req_valid;
      cmd.map_en    = (state_ff == ST_MAP);
      cmd.acc_en    = (state_ff == ST_ACC);
      cmd.walk_en   = (state_ff == ST_WALK);
      cmd.div_start = (state_ff == ST_TGT_GO) || (state_ff == ST_FLR_GO) ||
                      (state_ff == ST_GAP_GO);
      if ((state_ff == ST_FLR_GO) || (state_ff == ST_FLR_WAIT)) begin
         cmd.div_sel = DIV_FLOOR;
      end else if ((state_ff == ST_GAP_GO) || (state_ff == ST_GAP_WAIT)) begin
         cmd.div_sel = DIV_GAP;
      end else begin
         cmd.div_sel = DIV_TARGET;
      end
      cmd.scale_en  = (state_ff == ST_SCALE);
      cmd.emit_take = (state_ff == ST_EMIT) && !rsp_stall;
   end

   assign idx           = idx_ff;
   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = (state_ff == ST_EMIT);
   assign rsp_last_band = (state_ff == ST_EMIT) && (idx_ff == LAST_BAND);

   a_last_result_idles: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_band) |=> (state_ff == ST_IDLE))
      else $error("final band result did not return the controller to idle");

   a_div_not_instant: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> !sts.div_done)
      else $error("divider reported done right after start");

   a_accept_maps: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_MAP))
      else $error("accepted transaction did not enter band mapping");

   a_no_accept_while_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input accepted while band results are pending");

endmodule

@@ hdl/spectrum_band_peak_autorange_core.sv @@
// Spectrum band peak detector with automatic display range.
//
// Input channel (req_*): one FFT bin per transaction, index, magnitude and a
// frame-end flag. A transaction is taken when req_valid is high and req_stall
// is low. An ordinary bin goes through capture, band mapping and the update
// of the band maximum; req_stall is high during mapping and the update.
// A frame-end bin then starts the band walk: a step per band to gate levels
// and update held peaks, three divisions on the shared one-bit-per-cycle
// divider, a step to settle the scale, then NUM_BANDS result transactions.
// The input stays stalled until the last result is taken.
// Result channel (rsp_*): one transaction per band in band order, taken when
// rsp_valid is high and rsp_stall is low. While the receiver stalls, the
// result holds steady and the block waits.
// Configuration (csr_*): always ready; write only while the block is idle.
// Reset clears band maxima and held peaks, loads the register defaults and
// sets the display scale to 16.
module spectrum_band_peak_autorange_core #(
   parameter int NUM_BANDS = sbpa_pkg::NUM_BANDS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [sbpa_pkg::BIN_W-1:0]        req_bin_index,
   input  logic [sbpa_pkg::MAG_W-1:0]        req_magnitude,
   input  logic                              req_frame_end,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [sbpa_pkg::BAND_NUM_W-1:0]   rsp_band_number,
   output logic [sbpa_pkg::MAG_W-1:0]        rsp_band_level,
   output logic [sbpa_pkg::MAG_W-1:0]        rsp_band_peak,
   output logic [sbpa_pkg::MAG_W-1:0]        rsp_display_scale,
   output logic                              rsp_last_band,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sbpa_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sbpa_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import sbpa_pkg::*;

   localparam int BAND_W = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;

   dp_cmd_type        cmd;
   dp_status_type     sts;
   logic [BAND_W-1:0] idx;

   // The register file never pushes back.
   assign csr_ready = 1'b1;

   // The band number is the walk index, widened or cut to the field width.
   assign rsp_band_number = BAND_NUM_W'(idx);

   sbpa_ctrl #(
      .NUM_BANDS (NUM_BANDS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .rsp_stall     (rsp_stall),
      .sts           (sts),
      .cmd           (cmd),
      .idx           (idx),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_last_band (rsp_last_band)
   );

   // The datapath holds the registers, band state and the shared divider.
   sbpa_datapath #(
      .NUM_BANDS (NUM_BANDS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_bin_index     (req_bin_index),
      .req_magnitude     (req_magnitude),
      .req_frame_end     (req_frame_end),
      .cmd               (cmd),
      .idx               (idx),
      .sts               (sts),
      .rsp_band_level    (rsp_band_level),
      .rsp_band_peak     (rsp_band_peak),
      .rsp_display_scale (rsp_display_scale)
   );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import sbpa_pkg::*;

   localparam int NB = NUM_BANDS_DEF;

   // Held peaks decay by 15/16 on every frame that does not refresh them.
   localparam int unsigned DECAY_NUM = 15;
   localparam int unsigned DECAY_DEN = 16;

   localparam int LAST_PHASE     = 10;
   localparam int PRESSURE_PHASE = 8;
   localparam int PHASE_ITEMS    = 17;
   localparam int HOLD_CYCLES    = 400;
   localparam int SETTLE_CYCLES  = 10;
   localparam int DRAIN_CYCLES   = 100;
   localparam int QUIET_LIMIT    = 4000;
   localparam int SHOWN_ERRORS   = 10;

   typedef struct packed {
      logic [BIN_W-1:0]    first_bin;
      logic [BPB_W-1:0]    bins_per_band;
      logic [MAG_W-1:0]    noise_floor;
      logic [MARGIN_W-1:0] margin_num;
      logic [MARGIN_W-1:0] margin_den;
      logic [RATE_W-1:0]   attack_div;
      logic [RATE_W-1:0]   release_div;
   } band_cfg_type;

   typedef struct packed {
      logic [BAND_NUM_W-1:0] number;
      logic [MAG_W-1:0]      level;
      logic [MAG_W-1:0]      peak;
      logic [MAG_W-1:0]      scale;
      logic                  last;
   } band_report_type;

   // One probe bin. Where "typed" is set, the reports of the frame it closes are
   // the same for every band and are spelled out here instead of predicted.
   typedef struct packed {
      logic [BIN_W-1:0] bin;
      logic [MAG_W-1:0] mag;
      logic             fend;
      logic             typed;
      logic [MAG_W-1:0] level;
      logic [MAG_W-1:0] peak;
      logic [MAG_W-1:0] scale;
   } probe_row_type;

   localparam logic [CSR_INDEX_W-1:0] REG_ORDER [7] = '{
      CSR_FIRST_BIN, CSR_BINS_PER_BAND, CSR_NOISE_FLOOR, CSR_MARGIN_NUM,
      CSR_MARGIN_DEN, CSR_ATTACK_DIV, CSR_RELEASE_DIV
   };

   localparam band_cfg_type RESET_CFG =
      '{6'd1, 4'd2, 16'd10, 4'd8, 4'd5, 12'd12, 12'd1000};

   // Fixed corner settings. The first is the widest headroom with the fastest
   // tracking and no floor. The second maps only bin 63 and gates everything
   // below full scale. The third has zero bins per band, a zero margin and zero
   // divisors, so nothing maps and every divisor acts as one. The fourth uses
   // bands wider than the bin range can fill, and the last is a mid setting
   // with the largest margin numerator and denominator.
   localparam band_cfg_type PRESETS [5] = '{
      '{6'd0,  4'd1,  16'd0,     4'd15, 4'd1,  12'd1,    12'd1},
      '{6'd63, 4'd8,  16'd65535, 4'd1,  4'd15, 12'd4095, 12'd4095},
      '{6'd0,  4'd0,  16'd100,   4'd0,  4'd0,  12'd0,    12'd0},
      '{6'd5,  4'd15, 16'd500,   4'd7,  4'd3,  12'd2,    12'd50},
      '{6'd2,  4'd3,  16'd1000,  4'd15, 4'd15, 12'd8,    12'd4}
   };

   // Probe table, run under the reset register values: the first bin of band
   // zero is 1 and each band spans two bins, so bins 1 to 16 map and bin 0 and
   // bins 17 to 63 are ignored. The first frame end, on an ignored bin right
   // after reset, leaves every band quiet, and the scale stays at floor times
   // margin, which is the reset value of 16.
   localparam probe_row_type PROBES [13] = '{
      '{6'd0,  16'd65535, 1'b1, 1'b1, 16'd0, 16'd0, SCALE_RESET},
      '{6'd63, 16'd65535, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
      '{6'd1,  16'd65535, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
      '{6'd16, 16'd65535, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
      '{6'd2,  16'd0,     1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
      '{6'd5,  16'd9,     1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
      '{6'd7,  16'd10,    1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
      '{6'd17, 16'd40000, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0},
      '{6'd3,  16'd100,   1'b1, 1'b0, 16'd0, 16'd0, 16'd0},
      '{6'd4,  16'd65535, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
      '{6'd0,  16'd0,     1'b1, 1'b0, 16'd0, 16'd0, 16'd0},
      '{6'd63, 16'd0,     1'b1, 1'b0, 16'd0, 16'd0, 16'd0},
      '{6'd9,  16'd12345, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [BIN_W-1:0]       req_bin_index = '0;
   logic [MAG_W-1:0]       req_magnitude = '0;
   logic                   req_frame_end = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [BAND_NUM_W-1:0]  rsp_band_number;
   logic [MAG_W-1:0]       rsp_band_level;
   logic [MAG_W-1:0]       rsp_band_peak;
   logic [MAG_W-1:0]       rsp_display_scale;
   logic                   rsp_last_band;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_FIRST_BIN;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Local copy of the register file and of the block state.
   band_cfg_type     cfg;
   logic [MAG_W-1:0] band_max [NB];
   logic [MAG_W-1:0] held_peak [NB];
   logic [MAG_W-1:0] walk_level [NB];
   logic [MAG_W-1:0] scale_now;

   band_report_type band_reports_due [$];
   int              errors = 0;

   // Idle percentages of the two sides, and the receiver hold-off request.
   int   tx_idle_pct = 26;
   int   rx_idle_pct = 86;
   logic hold_request = 1'b0;
   int   hold_left = 0;

   spectrum_band_peak_autorange_core #(.NUM_BANDS(NB)) DUT (
      .clock, .reset,
      .req_valid, .req_stall, .req_bin_index, .req_magnitude, .req_frame_end,
      .rsp_valid, .rsp_stall, .rsp_band_number, .rsp_band_level, .rsp_band_peak,
      .rsp_display_scale, .rsp_last_band,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void note_error(input string msg);
      errors++;
      if (errors <= SHOWN_ERRORS) begin
         $display("%s", msg);
      end
   endfunction

   // Value times margin_num / margin_den, saturated to 16 bits.
   function automatic int unsigned with_margin(input int unsigned v);
      int unsigned t;
      t = v * cfg.margin_num / ((cfg.margin_den == 0) ? 1 : int'(cfg.margin_den));
      return (t > 65535) ? 65535 : t;
   endfunction

   // Folds one accepted bin into the band maxima. On a frame end it also walks
   // the bands, updates the held peaks and the display scale, and leaves the
   // gated levels in walk_level. Returns 1 when the bin closed a frame.
   function automatic bit fold_bin(input logic [BIN_W-1:0] bin,
                                   input logic [MAG_W-1:0] mag, input logic fend);
      int unsigned band, v, loudest, target, s, floor_s;
      if (cfg.bins_per_band != 0 && bin >= cfg.first_bin) begin
         band = int'(bin - cfg.first_bin) / int'(cfg.bins_per_band);
         if (band < NB && mag > band_max[band]) begin
            band_max[band] = mag;
         end
      end
      if (!fend) begin
         return 1'b0;
      end
      loudest = 32'(cfg.noise_floor);
      for (int b = 0; b < NB; b++) begin
         v = 32'(band_max[b]);
         if (v < cfg.noise_floor) begin
            v = 0;
         end
         walk_level[b] = v[MAG_W-1:0];
         if (v >= held_peak[b]) begin
            held_peak[b] = v[MAG_W-1:0];
         end else begin
            held_peak[b] = MAG_W'(held_peak[b] * DECAY_NUM / DECAY_DEN);
         end
         if (v > loudest) begin
            loudest = v;
         end
         band_max[b] = '0;
      end
      // The scale moves a fraction of the gap toward the target, then is
      // clamped from below at floor times margin.
      target = with_margin(loudest);
      s = 32'(scale_now);
      if (target > s) begin
         s += (target - s) / ((cfg.attack_div == 0) ? 1 : int'(cfg.attack_div));
      end else if (s > target) begin
         s -= (s - target) / ((cfg.release_div == 0) ? 1 : int'(cfg.release_div));
      end
      floor_s = with_margin(32'(cfg.noise_floor));
      if (s < floor_s) begin
         s = floor_s;
      end
      scale_now = s[MAG_W-1:0];
      return 1'b1;
   endfunction

   // Offers one bin transaction, waits until the block takes it, and queues the
   // band reports that it causes. The sender idles at random before each
   // transaction; the payload changes only on a falling edge.
   task automatic offer_bin(input logic [BIN_W-1:0] bin, input logic [MAG_W-1:0] mag,
                            input logic fend, input logic typed = 1'b0,
                            input logic [MAG_W-1:0] t_level = '0,
                            input logic [MAG_W-1:0] t_peak = '0,
                            input logic [MAG_W-1:0] t_scale = '0);
      band_report_type r;
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_bin_index <= bin;
      req_magnitude <= mag;
      req_frame_end <= fend;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      if (fold_bin(bin, mag, fend)) begin
         for (int b = 0; b < NB; b++) begin
            r.number = BAND_NUM_W'(b);
            r.level  = typed ? t_level : walk_level[b];
            r.peak   = typed ? t_peak : held_peak[b];
            r.scale  = typed ? t_scale : scale_now;
            r.last   = (b == NB - 1);
            band_reports_due.push_back(r);
         end
      end
   endtask

   // Writes all seven registers, one write transaction each, while the block
   // is idle. The local register copy follows once the writes are done.
   task automatic load_config(input band_cfg_type c);
      logic [CSR_DATA_W-1:0] word;
      foreach (REG_ORDER[k]) begin
         case (REG_ORDER[k])
            CSR_FIRST_BIN:     word = CSR_DATA_W'(c.first_bin);
            CSR_BINS_PER_BAND: word = CSR_DATA_W'(c.bins_per_band);
            CSR_NOISE_FLOOR:   word = CSR_DATA_W'(c.noise_floor);
            CSR_MARGIN_NUM:    word = CSR_DATA_W'(c.margin_num);
            CSR_MARGIN_DEN:    word = CSR_DATA_W'(c.margin_den);
            CSR_ATTACK_DIV:    word = CSR_DATA_W'(c.attack_div);
            default:           word = CSR_DATA_W'(c.release_div);
         endcase
         @(negedge clock);
         csr_valid <= 1'b1;
         csr_index <= REG_ORDER[k];
         csr_wdata <= word;
         @(posedge clock);
         while (!csr_ready) begin
            @(posedge clock);
         end
      end
      @(negedge clock);
      csr_valid <= 1'b0;
      cfg = c;
   endtask

   // Receiver. It stalls at random per rx_idle_pct, except during a requested
   // hold-off, when it stalls without a break until hold_left, loaded from HOLD_CYCLES, runs out.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      end
   end

   // Monitor. Every report transaction is checked against the oldest
   // expectation, field by field.
   always @(posedge clock) begin
      band_report_type want, got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_band_number, rsp_band_level, rsp_band_peak, rsp_display_scale,
                 rsp_last_band};
         if (band_reports_due.size() == 0) begin
            note_error($sformatf({"%0t: unexpected band report: num=%0d level=%0d ",
                                  "peak=%0d scale=%0d last=%0d"},
                                 $time, got.number, got.level, got.peak, got.scale,
                                 got.last));
         end else begin
            want = band_reports_due.pop_front();
            if (got.number !== want.number || got.level !== want.level ||
                got.peak !== want.peak || got.scale !== want.scale ||
                got.last !== want.last) begin
               note_error($sformatf({"%0t: band report mismatch: expected num=%0d level=%0d ",
                                     "peak=%0d scale=%0d last=%0d, got num=%0d level=%0d ",
                                     "peak=%0d scale=%0d last=%0d"},
                                    $time, want.number, want.level, want.peak, want.scale,
                                    want.last, got.number, got.level, got.peak, got.scale,
                                    got.last));
            end
         end
      end
   end

   // Watchdog. It counts cycles in which no transaction of any kind completes
   // and ends the run once that count reaches QUIET_LIMIT.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("tb failed");
      $finish;
   end

   // Stimulus.
   initial begin
      band_cfg_type     c;
      int               budget, len, aim, span, pos, near;
      logic [MAG_W-1:0] mag;

      cfg = RESET_CFG;
      for (int b = 0; b < NB; b++) begin
         band_max[b]  = '0;
         held_peak[b] = '0;
      end
      scale_now = SCALE_RESET;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Phase zero: the probe table under the reset register values.
      foreach (PROBES[i]) begin
         offer_bin(PROBES[i].bin, PROBES[i].mag, PROBES[i].fend, PROBES[i].typed,
                   PROBES[i].level, PROBES[i].peak, PROBES[i].scale);
      end

      for (int phase = 1; phase <= LAST_PHASE; phase++) begin
         // Registers change only with the block idle: every report has come
         // back and the last bin has had time to work its way through.
         @(negedge clock);
         req_valid <= 1'b0;
         while (band_reports_due.size() != 0) begin
            @(posedge clock);
         end
         repeat (SETTLE_CYCLES) @(posedge clock);

         if (phase <= 3) begin
            tx_idle_pct = 26;
            rx_idle_pct = 86;
         end else if (phase <= 7) begin
            tx_idle_pct = 86;
            rx_idle_pct = 26;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end

         if (phase <= 4) begin
            c = PRESETS[phase - 1];
         end else if (phase == LAST_PHASE) begin
            c = PRESETS[4];
         end else begin
            c.first_bin     = BIN_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                                 : $urandom_range(0, 8));
            c.bins_per_band = BPB_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                                 : $urandom_range(1, 8));
            c.noise_floor   = MAG_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                                 : $urandom_range(0, 300));
            c.margin_num    = MARGIN_W'($urandom_range(0, 15));
            c.margin_den    = MARGIN_W'($urandom_range(0, 15));
            c.attack_div    = RATE_W'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 4095)
                                                                  : $urandom_range(0, 16));
            c.release_div   = RATE_W'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 4095)
                                                                  : $urandom_range(0, 16));
         end
         load_config(c);

         // Back-pressure: the receiver holds off for a long stretch while the
         // sender keeps offering bins, so the block fills and stalls its input.
         if (phase == PRESSURE_PHASE) begin
            hold_request = 1'b1;
         end

         // Random frames. Most bins fall inside the configured span; one frame
         // in eight scatters its bins over the whole range instead. Every frame
         // closes with a frame-end bin so that it produces its band reports.
         budget = PHASE_ITEMS;
         while (budget > 0) begin
            len  = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40)
                                               : $urandom_range(1, 16);
            aim  = ($urandom_range(0, 7) == 0) ? 0 : 85;
            span = ((cfg.bins_per_band == 0) ? 1 : int'(cfg.bins_per_band)) * NB;
            for (int i = 0; i < len; i++) begin
               pos = int'(cfg.first_bin) + int'($urandom_range(0, span - 1));
               if ($urandom_range(0, 99) >= aim || pos >= BIN_COUNT) begin
                  pos = int'($urandom_range(0, BIN_COUNT - 1));
               end
               case ($urandom_range(0, 9))
                  0:       mag = '0;
                  1:       mag = '1;
                  2: begin
                     // Right around the noise floor, to exercise the gating.
                     near = int'(cfg.noise_floor) + int'($urandom_range(0, 4)) - 2;
                     mag = (near < 0) ? '0 : (near > 65535) ? '1 : MAG_W'(near);
                  end
                  3, 4:    mag = MAG_W'($urandom_range(0, 255));
                  default: mag = MAG_W'($urandom_range(0, 65535));
               endcase
               offer_bin(BIN_W'(pos), mag, i == len - 1);
            end
            budget -= len;
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (band_reports_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0 && band_reports_due.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hdl/sbpa_pkg.sv
hdl/sbpa_divider.sv
hdl/sbpa_datapath.sv
hdl/sbpa_ctrl.sv
hdl/spectrum_band_peak_autorange_core.sv
tb/tb.sv
